[rtl/core/mrf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte step for the RTU request framer.
// No dependencies.
package mrf_pkg;

    localparam int unsigned FRAME_LEN   = 8;
    localparam int unsigned IDX_W       = $clog2(FRAME_LEN);
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // byte positions inside the frame
    localparam logic [IDX_W-1:0] BYTE_ID     = 3'd0;
    localparam logic [IDX_W-1:0] BYTE_FUNC   = 3'd1;
    localparam logic [IDX_W-1:0] BYTE_ADDR_H = 3'd2;
    localparam logic [IDX_W-1:0] BYTE_ADDR_L = 3'd3;
    localparam logic [IDX_W-1:0] BYTE_DATA_H = 3'd4;
    localparam logic [IDX_W-1:0] BYTE_DATA_L = 3'd5;
    localparam logic [IDX_W-1:0] BYTE_CRC_L  = 3'd6;
    localparam logic [IDX_W-1:0] BYTE_CRC_H  = 3'd7;

    // Modbus function codes
    localparam logic [7:0] FC_WRITE_COIL    = 8'h05;
    localparam logic [7:0] FC_READ_COIL     = 8'h01;
    localparam logic [7:0] FC_WRITE_HOLDING = 8'h06;
    localparam logic [7:0] FC_READ_INPUT    = 8'h04;
    localparam logic [7:0] FC_READ_DISCRETE = 8'h02;

    localparam logic [7:0] COIL_ON = 8'hFF;

    typedef enum logic [2:0] {
        CMD_WRITE_COIL    = 3'd0,
        CMD_READ_COIL     = 3'd1,
        CMD_WRITE_HOLDING = 3'd2,
        CMD_READ_INPUT    = 3'd3,
        CMD_READ_DISCRETE = 3'd4
    } t_cmd;

    // first six bytes of a frame, ready for serialising
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  func;
        logic [15:0] addr;
        logic [15:0] data;
    } t_hdr;

    // one byte through the reflected CRC-16, bit by bit
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/mrf_front.sv]
`timescale 1ns / 1ps
// Front end: accepts a request, decodes the command and builds the frame header.
// Depends on mrf_pkg.
module mrf_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [2:0]       i_command,
    input  logic [7:0]       i_slave_id,
    input  logic [15:0]      i_reg_address,
    input  logic [15:0]      i_write_value,
    output logic             o_hdr_valid,
    output mrf_pkg::t_hdr    o_hdr,
    input  logic             i_hdr_full
);

    logic           r_fv;
    logic           n_fv;
    mrf_pkg::t_hdr  r_hdr;
    mrf_pkg::t_hdr  n_hdr;
    logic           known;
    logic           acc;
    logic           hdr_wr;

    assign hdr_wr = r_fv && !i_hdr_full;
    assign o_full = r_fv && i_hdr_full;
    assign acc    = i_push && !o_full;

    always_comb begin
        known       = 1'b1;
        n_hdr.id    = i_slave_id;
        n_hdr.addr  = i_reg_address;
        n_hdr.func  = mrf_pkg::FC_READ_COIL;
        n_hdr.data  = 16'h0001;
        case (mrf_pkg::t_cmd'(i_command))
            mrf_pkg::CMD_WRITE_COIL: begin
                n_hdr.func = mrf_pkg::FC_WRITE_COIL;
                n_hdr.data = {(|i_write_value) ? mrf_pkg::COIL_ON : 8'h00, 8'h00};
            end
            mrf_pkg::CMD_READ_COIL: begin
                n_hdr.func = mrf_pkg::FC_READ_COIL;
            end
            mrf_pkg::CMD_WRITE_HOLDING: begin
                n_hdr.func = mrf_pkg::FC_WRITE_HOLDING;
                n_hdr.data = i_write_value;
            end
            mrf_pkg::CMD_READ_INPUT: begin
                n_hdr.func = mrf_pkg::FC_READ_INPUT;
            end
            mrf_pkg::CMD_READ_DISCRETE: begin
                n_hdr.func = mrf_pkg::FC_READ_DISCRETE;
            end
            default: begin
                // unknown command: item is swallowed
                known = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_fv = r_fv;
        if (acc) begin
            n_fv = known;
        end else if (hdr_wr) begin
            n_fv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else begin
            r_fv <= n_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hdr <= n_hdr;
        end
    end

    assign o_hdr_valid = r_fv;
    assign o_hdr       = r_hdr;

endmodule

[rtl/core/mrf_fifo.sv]
`timescale 1ns / 1ps
// Short header queue between front and back ends, first-word fall-through.
// Depends on mrf_pkg.
module mrf_fifo #(
    parameter int unsigned DEPTH = mrf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mrf_pkg::t_hdr  i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_nonempty,
    output mrf_pkg::t_hdr  o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    mrf_pkg::t_hdr  r_mem [DEPTH];
    logic [AW-1:0]  r_wptr;
    logic [AW-1:0]  n_wptr;
    logic [AW-1:0]  r_rptr;
    logic [AW-1:0]  n_rptr;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           wr;
    logic           rd;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign wr         = i_wr && !o_full;
    assign rd         = i_rd && o_nonempty;
    assign o_data     = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (wr) begin
            n_wptr = (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
        end
        if (rd) begin
            n_rptr = (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
        end
        n_count = r_count + CW'(wr) - CW'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("header queue count above depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> (r_wptr == r_rptr))
        else $error("header queue pointers disagree with count");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("header queue count missed a write");
`endif

endmodule

[rtl/core/mrf_back.sv]
`timescale 1ns / 1ps
// Back end: serialises a header into eight bytes and appends the CRC-16.
// Depends on mrf_pkg.
module mrf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hdr_nonempty,
    input  mrf_pkg::t_hdr  i_hdr,
    output logic           o_hdr_rd,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     o_frame_byte,
    output logic           o_last_byte
);

    localparam int unsigned IW = mrf_pkg::IDX_W;

    mrf_pkg::t_hdr   r_hdr;
    logic            r_busy;
    logic            n_busy;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   n_idx;
    logic [15:0]     r_crc;
    logic [15:0]     n_crc;
    logic            r_ov;
    logic            n_ov;
    logic [7:0]      r_ob;
    logic [7:0]      n_ob;
    logic            r_ol;
    logic            n_ol;
    logic            adv;
    logic            emit;
    logic            at_end;
    logic            load;
    logic [7:0]      cur_byte;

    assign adv      = !r_ov || pop;
    assign emit     = adv && r_busy;
    assign at_end   = (r_idx == mrf_pkg::BYTE_CRC_H);
    assign load     = i_hdr_nonempty && (!r_busy || (emit && at_end));
    assign o_hdr_rd = load;

    always_comb begin
        case (r_idx)
            mrf_pkg::BYTE_ID:     cur_byte = r_hdr.id;
            mrf_pkg::BYTE_FUNC:   cur_byte = r_hdr.func;
            mrf_pkg::BYTE_ADDR_H: cur_byte = r_hdr.addr[15:8];
            mrf_pkg::BYTE_ADDR_L: cur_byte = r_hdr.addr[7:0];
            mrf_pkg::BYTE_DATA_H: cur_byte = r_hdr.data[15:8];
            mrf_pkg::BYTE_DATA_L: cur_byte = r_hdr.data[7:0];
            mrf_pkg::BYTE_CRC_L:  cur_byte = r_crc[7:0];
            mrf_pkg::BYTE_CRC_H:  cur_byte = r_crc[15:8];
            default:              cur_byte = r_crc[15:8];
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_crc  = r_crc;
        n_ov   = r_ov;
        n_ob   = r_ob;
        n_ol   = r_ol;
        if (adv) begin
            n_ov = emit;
        end
        if (emit) begin
            n_ob  = cur_byte;
            n_ol  = at_end;
            n_idx = r_idx + 1'b1;
            // CRC runs over the six header bytes only
            if (r_idx < mrf_pkg::BYTE_CRC_L) begin
                n_crc = mrf_pkg::crc_byte(r_crc, cur_byte);
            end
            if (at_end) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_idx  = '0;
            n_crc  = mrf_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_ov   <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
        r_ob  <= n_ob;
        r_ol  <= n_ol;
        if (load) begin
            r_hdr <= i_hdr;
        end
    end

    assign empty        = !r_ov;
    assign o_frame_byte = r_ob;
    assign o_last_byte  = r_ol;

`ifndef NO_ASSERTIONS
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0))
        else $error("byte index not parked while idle");
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_ol == ($past(r_idx) == mrf_pkg::BYTE_CRC_H)))
        else $error("last marker on wrong byte");
    a_no_load_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !(emit && at_end)) |-> !o_hdr_rd)
        else $error("header taken in the middle of a frame");
`endif

endmodule

[rtl/core/modbus_rtu_request_framer_top.sv]
`timescale 1ns / 1ps
// Top level of the Modbus RTU request framer: front end, header queue, back end.
// Depends on mrf_pkg, mrf_front, mrf_fifo and mrf_back.
//
//  channel   handshake          payload
//  request   push / full        i_command, i_slave_id, i_reg_address, i_write_value
//  frame     empty / pop        o_frame_byte, o_last_byte
//
// Each request gives eight bytes, one per cycle while pop is held; the byte
// serialiser folds one header byte a cycle into the CRC unless stalled.
// A request passes the front-end, queue and back-end header registers. Unknown
// commands are taken and dropped. Synchronous active-low reset empties every
// stage. A stalled output takes requests until the queue and front end are full.
module modbus_rtu_request_framer_top #(
    parameter int unsigned QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_slave_id,
    input  logic [15:0] i_reg_address,
    input  logic [15:0] i_write_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte
);

    logic           f_valid;
    mrf_pkg::t_hdr  f_hdr;
    logic           q_full;
    logic           q_rd;
    logic           q_nonempty;
    mrf_pkg::t_hdr  q_hdr;

    mrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_slave_id    (i_slave_id),
        .i_reg_address (i_reg_address),
        .i_write_value (i_write_value),
        .o_hdr_valid   (f_valid),
        .o_hdr         (f_hdr),
        .i_hdr_full    (q_full)
    );

    mrf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (f_valid),
        .i_data     (f_hdr),
        .o_full     (q_full),
        .i_rd       (q_rd),
        .o_nonempty (q_nonempty),
        .o_data     (q_hdr)
    );

    mrf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hdr_nonempty (q_nonempty),
        .i_hdr          (q_hdr),
        .o_hdr_rd       (q_rd),
        .empty          (empty),
        .pop            (pop),
        .o_frame_byte   (o_frame_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule
